// ----- src/gasp_pkg.sv -----
// Shared types and constants for the glyph atlas shelf packer.
// Used by the shelf evaluator and the top level; depends on nothing.
`default_nettype none

package gasp_pkg;

    localparam int RECT_W     = 15;  // request width and height fields
    localparam int COORD_W    = 14;  // place_x and place_y fields
    localparam int SIZE_W     = 15;  // reported atlas side
    localparam int SIDE_W     = 16;  // internal atlas side, holds up to 32768
    localparam int LOG2_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int H10_W      = 19;  // ten times a request height
    localparam int ROWH_W     = 16;  // height of a newly opened shelf
    localparam int PROD_W     = 31;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    // Exact h / 10 for any 16-bit h: (h * 52429) >> 19.
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [RECT_W-1:0] RESET_NEXT_TOP = 15'd2;

    localparam logic [STATUS_W-1:0] STATUS_PLACED       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL   = 2'd2;

    // One row of the shelf table as it is kept in memory.
    typedef struct packed {
        logic [RECT_W-1:0] top;
        logic [RECT_W-1:0] height;
        logic [RECT_W-1:0] used;
    } shelf_t;

    // Verdict of the evaluator on one shelf.
    typedef struct packed {
        logic qualifies;
        logic take;
    } eval_res_t;

endpackage

`default_nettype wire

// ----- src/gasp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the shelf table; depends on nothing.
`default_nettype none

module gasp_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 64
) (
    input  wire                                       aclk,
    input  wire                                       we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                          wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- src/gasp_eval.sv -----
// Shelf evaluator: decides whether one shelf can take the request and whether
// it beats the best shelf so far. Depends on gasp_pkg.
`default_nettype none

module gasp_eval (
    input  wire  gasp_pkg::shelf_t                   entry,
    input  wire  [gasp_pkg::RECT_W-1:0]              rect_w,
    input  wire  [gasp_pkg::RECT_W-1:0]              rect_h,
    input  wire  [gasp_pkg::H10_W-1:0]               h_times10,
    input  wire  [gasp_pkg::SIDE_W-1:0]              side,
    input  wire                                      have_best,
    input  wire  [gasp_pkg::RECT_W-1:0]              best_height,
    output gasp_pkg::eval_res_t                      res
);
    import gasp_pkg::*;

    logic [H10_W-1:0]  sh_times7;
    logic [SIDE_W-1:0] end_x;
    logic              ratio_ok;

    always_comb begin
        sh_times7 = {1'b0, entry.height, 3'b000} - {4'b0000, entry.height};
        end_x     = {1'b0, entry.used} + {1'b0, rect_w};
        // The shelf may be at most 10/7 of the request height and no lower than it.
        ratio_ok  = (sh_times7 <= h_times10) && (rect_h <= entry.height);
        res.qualifies = (entry.height != '0) && ratio_ok && (end_x <= side);
        // On equal heights the later shelf wins.
        res.take = res.qualifies && (!have_best || (entry.height <= best_height));
    end

endmodule

`default_nettype wire

// ----- src/glyph_atlas_shelf_packer_core.sv -----
// Top level of the glyph atlas shelf packer: sequencer, atlas state and stream ports.
// Depends on gasp_pkg, gasp_ram and gasp_eval.
`default_nettype none

// Each request transfer tries to place one rectangle on a shelf of a square atlas
// and returns one result transfer. The block takes a request only when it is idle
// and works on it alone. The shelf table is read one row per cycle from its RAM
// to find the best existing shelf. A request that opens a new shelf then works out
// the height of that shelf and doubles the atlas side until the shelf fits.
// A finished result waits in the output register; the block takes the next
// request while it waits and stalls only before handing over a second result.
// After reset the atlas side is START_DIM, no shelf exists and the first shelf
// opens at row 2. Status is 0 when placed, 1 when the atlas cannot grow past
// MAX_DIM (doubling done in that request is kept), 2 when the shelf table is full.
module glyph_atlas_shelf_packer_core #(
    parameter int MAX_SHELVES = 64,
    parameter int MAX_DIM     = 16384,
    parameter int START_DIM   = 256
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    // [14:0] rect_width, [29:15] rect_height, [31:30] zero
    input  wire  [gasp_pkg::S_TDATA_W-1:0]         s_tdata,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    // [13:0] place_x, [27:14] place_y, [42:28] atlas_size, [43] atlas_grew,
    // [47:44] zero
    output logic [gasp_pkg::M_TDATA_W-1:0]         m_tdata,
    // [1:0] status
    output logic [gasp_pkg::STATUS_W-1:0]          m_tuser
);
    import gasp_pkg::*;

    localparam int IDX_W      = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int CNT_W      = $clog2(MAX_SHELVES + 1);
    localparam int LOG2_START = $clog2(START_DIM + 1) - 1;
    localparam int SHELF_W    = $bits(shelf_t);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_ROWH   = 3'd4;
    localparam logic [2:0] ST_GROW   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    shelf_count_reg, shelf_count_next;
    logic [RECT_W-1:0]   next_top_reg, next_top_next;
    logic [LOG2_W-1:0]   atlas_log2_reg, atlas_log2_next;
    logic                found_reg, found_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [RECT_W-1:0]   w_reg, w_next;
    logic [RECT_W-1:0]   h_reg, h_next;
    logic [H10_W-1:0]    h10_reg, h10_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [RECT_W-1:0]   best_h_reg, best_h_next;
    logic [RECT_W-1:0]   best_used_reg, best_used_next;
    logic [RECT_W-1:0]   best_top_reg, best_top_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ROWH_W-1:0]   rowh_reg, rowh_next;
    logic [COORD_W-1:0]  res_x_reg, res_x_next;
    logic [COORD_W-1:0]  res_y_reg, res_y_next;
    logic                res_grew_reg, res_grew_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    shelf_t              ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [SHELF_W-1:0]  ram_rdata;
    shelf_t              entry;
    eval_res_t           ev;

    logic [SIDE_W-1:0]   side;
    logic [SIDE_W:0]     side_x2;
    logic [SIDE_W:0]     row_end;
    logic                need_grow;
    logic                last_entry;
    logic                in_xfer;
    logic                out_free;

    gasp_ram #(
        .WIDTH (SHELF_W),
        .DEPTH (MAX_SHELVES)
    ) u_shelf_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry = shelf_t'(ram_rdata);

    gasp_eval u_eval (
        .entry       (entry),
        .rect_w      (w_reg),
        .rect_h      (h_reg),
        .h_times10   (h10_reg),
        .side        (side),
        .have_best   (found_reg),
        .best_height (best_h_reg),
        .res         (ev)
    );

    assign side       = SIDE_W'(1) << atlas_log2_reg;
    assign side_x2    = {side, 1'b0};
    assign row_end    = {2'b00, next_top_reg} + {1'b0, rowh_reg};
    assign need_grow  = (row_end >= {1'b0, side}) || ({1'b0, w_reg} >= side);
    assign last_entry = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == shelf_count_reg);
    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next       = state_reg;
        shelf_count_next = shelf_count_reg;
        next_top_next    = next_top_reg;
        atlas_log2_next  = atlas_log2_reg;
        found_next       = found_reg;
        m_tvalid_next    = m_tvalid_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        h10_next         = h10_reg;
        scan_idx_next    = scan_idx_reg;
        best_idx_next    = best_idx_reg;
        best_h_next      = best_h_reg;
        best_used_next   = best_used_reg;
        best_top_next    = best_top_reg;
        prod_next        = prod_reg;
        rowh_next        = rowh_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_grew_next    = res_grew_reg;
        res_status_next  = res_status_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        ram_we           = 1'b0;
        ram_waddr        = best_idx_reg;
        ram_wdata        = '{top: best_top_reg, height: best_h_reg,
                             used: RECT_W'({1'b0, best_used_reg} + {1'b0, w_reg})};
        ram_raddr        = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    w_next        = s_tdata[RECT_W-1:0];
                    h_next        = s_tdata[2*RECT_W-1:RECT_W];
                    h10_next      = {1'b0, s_tdata[2*RECT_W-1:RECT_W], 3'b000}
                                  + {3'b000, s_tdata[2*RECT_W-1:RECT_W], 1'b0};
                    found_next    = 1'b0;
                    res_grew_next = 1'b0;
                    scan_idx_next = '0;
                    ram_raddr     = '0;
                    state_next    = (shelf_count_reg == '0) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Data for scan_idx_reg arrives now; the next row is fetched meanwhile.
                ram_raddr = scan_idx_reg + IDX_W'(1);
                if (ev.take) begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_idx_reg;
                    best_h_next    = entry.height;
                    best_used_next = entry.used;
                    best_top_next  = entry.top;
                end
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (last_entry) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (found_reg) begin
                    ram_we          = 1'b1;
                    res_x_next      = best_used_reg[COORD_W-1:0];
                    res_y_next      = best_top_reg[COORD_W-1:0];
                    res_status_next = STATUS_PLACED;
                    state_next      = ST_DONE;
                end else if (shelf_count_reg == CNT_W'(MAX_SHELVES)) begin
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_status_next = STATUS_TABLE_FULL;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                prod_next  = PROD_W'(h_reg) * PROD_W'(DIV10_MUL);
                state_next = ST_ROWH;
            end
            ST_ROWH: begin
                rowh_next  = {1'b0, h_reg} + ROWH_W'(prod_reg >> DIV10_SHIFT);
                state_next = ST_GROW;
            end
            ST_GROW: begin
                // One doubling of the atlas side per cycle until the new shelf fits or MAX_DIM is reached.
                if (need_grow) begin
                    if (side_x2 <= (SIDE_W + 1)'(MAX_DIM)) begin
                        atlas_log2_next = atlas_log2_reg + LOG2_W'(1);
                        res_grew_next   = 1'b1;
                    end else begin
                        res_x_next      = '0;
                        res_y_next      = '0;
                        res_status_next = STATUS_OUT_OF_SPACE;
                        state_next      = ST_DONE;
                    end
                end else begin
                    ram_we           = 1'b1;
                    ram_waddr        = shelf_count_reg[IDX_W-1:0];
                    ram_wdata        = '{top: next_top_reg, height: rowh_reg[RECT_W-1:0],
                                         used: w_reg};
                    shelf_count_next = shelf_count_reg + CNT_W'(1);
                    next_top_next    = row_end[RECT_W-1:0];
                    res_x_next       = '0;
                    res_y_next       = next_top_reg[COORD_W-1:0];
                    res_status_next  = STATUS_PLACED;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, res_grew_reg, side[SIZE_W-1:0],
                                     res_y_reg, res_x_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            shelf_count_reg <= '0;
            next_top_reg    <= RESET_NEXT_TOP;
            atlas_log2_reg  <= LOG2_W'(LOG2_START);
            found_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            shelf_count_reg <= shelf_count_next;
            next_top_reg    <= next_top_next;
            atlas_log2_reg  <= atlas_log2_next;
            found_reg       <= found_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg          <= w_next;
        h_reg          <= h_next;
        h10_reg        <= h10_next;
        scan_idx_reg   <= scan_idx_next;
        best_idx_reg   <= best_idx_next;
        best_h_reg     <= best_h_next;
        best_used_reg  <= best_used_next;
        best_top_reg   <= best_top_next;
        prod_reg       <= prod_next;
        rowh_reg       <= rowh_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_grew_reg   <= res_grew_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        shelf_count_reg <= CNT_W'(MAX_SHELVES))
        else $error("shelf count exceeds the table depth");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CNT_W'(scan_idx_reg) < shelf_count_reg))
        else $error("scan reads a shelf row that was never written");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while the previous one is still at work");

    a_write_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (CNT_W'($past(ram_waddr)) < shelf_count_reg))
        else $error("shelf write outside the occupied part of the table");
`endif

endmodule

`default_nettype wire
